// ===== hdl/fcwm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcwm_pkg
// Shared constants, types and helpers of the four-channel window median filter.
// ----------------------------------------------------------------------------
package fcwm_pkg;

    localparam int WINDOW    = 5;   // samples per median window, 1 .. 15
    localparam int CHANNELS  = 4;   // active sensor channels, 1 .. 4
    localparam int NUM_IN_CH = 4;   // channels carried on the ports

    localparam int MM_W     = 13;
    localparam int STATUS_W = 8;
    localparam int DIST_W   = 14;
    localparam int CH_IN_W  = MM_W + STATUS_W;

    localparam int IN_DATA_W  = ((NUM_IN_CH * CH_IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NUM_IN_CH * DIST_W + 7) / 8) * 8;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int MID_HI = WINDOW / 2;
    localparam int MID_LO = (WINDOW > 1) ? (WINDOW / 2 - 1) : 0;

    localparam logic [STATUS_W-1:0] STATUS_BAD = STATUS_W'(4);
    localparam logic [MM_W-1:0]     NO_TARGET  = MM_W'(8191);
    localparam logic [DIST_W-1:0]   DIST_NONE  = {DIST_W{1'b1}};

    typedef logic signed [DIST_W-1:0] t_dist;
    typedef t_dist [CHANNELS-1:0]     t_lanes;

    // One hop of the sorting chain: a value per channel plus a shared valid.
    typedef struct packed {
        logic   valid;
        t_lanes val;
    } t_link;

    // A sample with a bad status or no target becomes -1.
    function automatic t_dist clean_sample(input logic [MM_W-1:0] mm,
                                           input logic [STATUS_W-1:0] status);
        t_dist res;
        if (status == STATUS_BAD || mm == NO_TARGET) begin
            res = DIST_NONE;
        end else begin
            res = t_dist'({1'b0, mm});
        end
        return res;
    endfunction

    // Mean of two values, truncated toward zero.
    function automatic t_dist mean_trunc(input t_dist a, input t_dist b);
        logic signed [DIST_W:0] sum;
        logic signed [DIST_W:0] adj;
        sum = {a[DIST_W-1], a} + {b[DIST_W-1], b};
        adj = sum + {{DIST_W{1'b0}}, sum[DIST_W]};
        return t_dist'(adj >>> 1);
    endfunction

endpackage

// ===== hdl/fcwm_hist.sv =====
// ----------------------------------------------------------------------------
// fcwm_hist
// Per-channel history line; shifts in a new sample or rotates to feed the sorter.
// ----------------------------------------------------------------------------
module fcwm_hist
    import fcwm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  logic   i_rot,
    input  t_lanes i_new,
    output t_lanes o_tap
);

    t_lanes r_line [WINDOW];
    t_lanes n_head;

    // The window holds the last samples as a set, so a shift line gives the
    // same contents as a rotating write slot. A full rotation restores order.
    assign n_head = i_push ? i_new : r_line[WINDOW-1];
    assign o_tap  = r_line[WINDOW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_line[k] <= '0;
            end
        end else if (i_push || i_rot) begin
            r_line[0] <= n_head;
            for (int k = 1; k < WINDOW; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

endmodule

// ===== hdl/fcwm_cell.sv =====
// ----------------------------------------------------------------------------
// fcwm_cell
// Insertion-sort cell: keeps the smallest value seen, passes larger ones on.
// ----------------------------------------------------------------------------
module fcwm_cell
    import fcwm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_clear,
    input  t_link  i_link,
    output t_link  o_link,
    output t_lanes o_val
);

    logic   r_full;
    t_lanes r_val;
    t_link  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full       <= 1'b0;
            r_out.valid  <= 1'b0;
        end else if (i_clear) begin
            r_full       <= 1'b0;
            r_out.valid  <= 1'b0;
        end else if (i_link.valid) begin
            r_full      <= 1'b1;
            r_out.valid <= r_full;
            for (int c = 0; c < CHANNELS; c++) begin
                if (!r_full) begin
                    r_val[c] <= i_link.val[c];
                end else if ($signed(i_link.val[c]) < $signed(r_val[c])) begin
                    r_val[c]     <= i_link.val[c];
                    r_out.val[c] <= r_val[c];
                end else begin
                    r_out.val[c] <= i_link.val[c];
                end
            end
        end else begin
            r_out.valid <= 1'b0;
        end
    end

    assign o_link = r_out;
    assign o_val  = r_val;

endmodule

// ===== hdl/four_channel_window_median_top.sv =====
// ----------------------------------------------------------------------------
// four_channel_window_median_top
// Sliding-window median of four distance sensor channels.
// ----------------------------------------------------------------------------
// A request passes the states feed, settle and output before its result is
// registered; the output state waits while the result port stalls. A new
// request is taken only back in idle, after the history line has rotated once
// through the sorting cell chain and the chain has settled.
// Reset: synchronous, active low; clears the history to zeros and the control.
// ----------------------------------------------------------------------------
module four_channel_window_median_top
    import fcwm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input request, tdata from bit 0 up: mm_front, status_front, mm_left,
    // status_left, mm_right, status_right, mm_back, status_back, zero fill.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Result request, tdata from bit 0 up: dist_front, dist_left, dist_right,
    // dist_back, each 14-bit two's complement.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    // The sequencer walks through four phases. In idle it takes a request and
    // shifts the cleaned samples into the history. In feed the history rotates
    // once, streaming every stored sample into the first sort cell. In settle
    // the last values ripple down the chain. In output the median cell is
    // read into the result register once that register is free.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_SETTLE,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_m_tvalid;
    logic [OUT_DATA_W-1:0] r_m_tdata;
    logic [OUT_DATA_W-1:0] n_m_tdata;

    logic   accept;
    logic   feeding;
    logic   out_free;
    logic   load_out;
    t_lanes new_samples;
    t_lanes hist_tap;
    t_link  links [WINDOW+1];
    t_lanes cell_val [WINDOW];
    t_lanes median;

    assign accept   = i_s_tvalid && (r_state == S_IDLE);
    assign feeding  = (r_state == S_FEED);
    assign out_free = !r_m_tvalid || i_m_tready;
    assign load_out = (r_state == S_OUT) && out_free;

    // Clean each active channel's sample; unused input channels are ignored.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            new_samples[c] = clean_sample(i_s_tdata[c*CH_IN_W +: MM_W],
                                          i_s_tdata[c*CH_IN_W + MM_W +: STATUS_W]);
        end
    end

    fcwm_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_rot   (feeding),
        .i_new   (new_samples),
        .o_tap   (hist_tap)
    );

    // The sorting chain: after all values have passed, cell k holds the k-th
    // smallest value of every channel's window.
    assign links[0].valid = feeding;
    assign links[0].val   = hist_tap;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        fcwm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (accept),
            .i_link  (links[k]),
            .o_link  (links[k+1]),
            .o_val   (cell_val[k])
        );
    end

    // Odd windows take the middle cell, even windows the truncated mean of the
    // two middle cells.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if ((WINDOW % 2) == 1) begin
                median[c] = cell_val[MID_HI][c];
            end else begin
                median[c] = mean_trunc(cell_val[MID_HI][c], cell_val[MID_LO][c]);
            end
        end
    end

    // Result word: active channels carry their medians, unused fields are zero.
    always_comb begin
        n_m_tdata = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            n_m_tdata[c*DIST_W +: DIST_W] = median[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (load_out) begin
                r_m_tvalid <= 1'b1;
                r_m_tdata  <= n_m_tdata;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (accept) begin
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    if (r_cnt == CNT_W'(WINDOW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_SETTLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SETTLE: begin
                    if (r_cnt == CNT_W'(WINDOW - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

endmodule
